// ===== sv/lspb_pkg.sv =====
// ----------------------------------------------------------------------------
// lspb_pkg
// Shared codes and types for the LSPB Cartesian trajectory unit.
// ----------------------------------------------------------------------------
package lspb_pkg;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_INFEAS = 2'd2;

    // configuration register indexes
    localparam int         REG_IDX_BITS = 3;
    localparam logic [2:0] REG_START    = 3'd0;
    localparam logic [2:0] REG_END      = 3'd1;
    localparam logic [2:0] REG_SPEED    = 3'd2;
    localparam logic [2:0] REG_T0       = 3'd3;
    localparam logic [2:0] REG_T1       = 3'd4;

    // segment class of a queued sample
    localparam int         CL_BITS = 2;
    localparam logic [1:0] CL_HOLD = 2'd0;
    localparam logic [1:0] CL_ACC  = 2'd1;
    localparam logic [1:0] CL_DEC  = 2'd2;
    localparam logic [1:0] CL_CRU  = 2'd3;

    typedef struct packed {
        logic       ok;
        logic [1:0] status;
    } t_cfg_st;

endpackage

// ===== sv/lspb_in_if.sv =====
// ----------------------------------------------------------------------------
// lspb_in_if
// Sample-time channel: valid/ready with the requested tick.
// ----------------------------------------------------------------------------
interface lspb_in_if #(
    parameter int TIME_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] sample_time;

    modport source (output valid, output sample_time, input ready);
    modport sink   (input valid, input sample_time, output ready);
endinterface

// ===== sv/lspb_out_if.sv =====
// ----------------------------------------------------------------------------
// lspb_out_if
// Result channel: valid/ready with position, velocity and status.
// ----------------------------------------------------------------------------
interface lspb_out_if #(
    parameter int COORD_BITS = 20
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic signed [COORD_BITS-1:0] vel_x;
    logic signed [COORD_BITS-1:0] vel_y;
    logic signed [COORD_BITS-1:0] vel_z;
    logic [1:0]                   status;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output vel_x, output vel_y, output vel_z, output status,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input vel_x, input vel_y, input vel_z, input status,
                    output ready);
endinterface

// ===== sv/lspb_cfg.sv =====
// ----------------------------------------------------------------------------
// lspb_cfg
// Configuration registers and move setup: deltas, path length (bit-serial
// square root), cruise product and feasibility. Reruns after every write.
// ----------------------------------------------------------------------------
module lspb_cfg #(
    parameter int COORD_BITS = 20,
    parameter int TIME_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lspb_pkg::REG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [3*COORD_BITS-1:0]             i_cfg_wdata,
    output logic [3*COORD_BITS-1:0]             o_start,
    output logic [3*COORD_BITS-1:0]             o_mag,
    output logic [2:0]                          o_neg,
    output logic [COORD_BITS+7:0]               o_vq,
    output logic [TIME_BITS-1:0]                o_t0,
    output logic [TIME_BITS-1:0]                o_t1,
    output logic [TIME_BITS-1:0]                o_tt,
    output logic [COORD_BITS+8:0]               o_lq,
    output logic [COORD_BITS+8:0]               o_k,
    output lspb_pkg::t_cfg_st                   o_st
);
    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int LW  = CB + 9;
    localparam int VW  = CB + 8;
    localparam int SSW = 2 * CB + 2;
    localparam int KW  = VW + TIME_BITS;
    localparam int PW  = 3 * CB;
    localparam int IW  = $clog2(LW);

    localparam logic [2:0] S_SQ   = 3'd0;
    localparam logic [2:0] S_LD   = 3'd1;
    localparam logic [2:0] S_RT   = 3'd2;
    localparam logic [2:0] S_VT   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [PW-1:0]        r_start, r_end;
    logic [CB-1:0]        r_speed;
    logic [TIME_BITS-1:0] r_t0, r_t1;

    logic [2:0]           r_st;
    logic [1:0]           r_ax;
    logic [SSW-1:0]       r_sumsq;
    logic [2*LW-1:0]      r_rx;
    logic [LW+1:0]        r_rem;
    logic [LW-1:0]        r_res;
    logic [IW-1:0]        r_it;
    logic [KW-1:0]        r_vt;
    logic [LW-1:0]        r_k;
    logic [1:0]           r_status;
    logic                 r_ok;

    logic [CB-1:0]        w_mag [3];
    logic [2:0]           w_neg;
    logic [VW-1:0]        w_vq;
    logic [TIME_BITS-1:0] w_tt;
    logic [2*CB-1:0]      w_sq;
    logic [LW+3:0]        w_rem2, w_trial;
    logic                 w_fit;
    logic [1:0]           n_status;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic [DW-1:0] s, e, d;
            s = {r_start[a*CB+CB-1], r_start[a*CB +: CB]};
            e = {r_end[a*CB+CB-1], r_end[a*CB +: CB]};
            d = e - s;
            w_neg[a] = d[DW-1];
            w_mag[a] = d[DW-1] ? CB'(~d + 1'b1) : d[CB-1:0];
        end
    end

    assign w_vq    = {r_speed, 8'b0};
    assign w_tt    = r_t1 - r_t0;
    assign w_sq    = w_mag[r_ax] * w_mag[r_ax];
    assign w_rem2  = {r_rem, r_rx[2*LW-1 -: 2]};
    assign w_trial = {2'b00, r_res, 2'b01};
    assign w_fit   = (r_vt > KW'(r_res)) && (r_vt <= KW'({r_res, 1'b0}));

    always_comb begin
        priority if (r_sumsq == '0) begin
            n_status = lspb_pkg::ST_ZERO;
        end else if (r_t1 <= r_t0) begin
            n_status = lspb_pkg::ST_INFEAS;
        end else if (!w_fit) begin
            n_status = lspb_pkg::ST_INFEAS;
        end else begin
            n_status = lspb_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
            r_speed <= '0;
            r_t0    <= '0;
            r_t1    <= '0;
            r_st    <= S_SQ;
            r_ax    <= '0;
            r_sumsq <= '0;
            r_ok    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lspb_pkg::REG_START: r_start <= i_cfg_wdata;
                lspb_pkg::REG_END:   r_end   <= i_cfg_wdata;
                lspb_pkg::REG_SPEED: r_speed <= i_cfg_wdata[CB-1:0];
                lspb_pkg::REG_T0:    r_t0    <= i_cfg_wdata[TIME_BITS-1:0];
                lspb_pkg::REG_T1:    r_t1    <= i_cfg_wdata[TIME_BITS-1:0];
                default: ;
            endcase
            r_st    <= S_SQ;
            r_ax    <= '0;
            r_sumsq <= '0;
            r_ok    <= 1'b0;
        end else begin
            unique case (r_st)
                S_SQ: begin
                    r_sumsq <= r_sumsq + SSW'(w_sq);
                    r_ax    <= r_ax + 1'b1;
                    if (r_ax == 2'd2) begin
                        r_st <= S_LD;
                    end
                end
                S_LD: begin
                    r_st <= S_RT;
                end
                S_RT: begin
                    if (r_it == '0) begin
                        r_st <= S_VT;
                    end
                end
                S_VT: begin
                    r_st <= S_CHK;
                end
                S_CHK: begin
                    r_ok <= 1'b1;
                    r_st <= S_DONE;
                end
                default: ;
            endcase
        end
    end

    // square root datapath, one result bit per cycle, then cruise product, k and status
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_LD: begin
                r_rx  <= {r_sumsq, 16'b0};
                r_rem <= '0;
                r_res <= '0;
                r_it  <= IW'(LW - 1);
            end
            S_RT: begin
                r_rx <= {r_rx[2*LW-3:0], 2'b00};
                r_it <= r_it - 1'b1;
                if (w_rem2 >= w_trial) begin
                    r_rem <= (LW+2)'(w_rem2 - w_trial);
                    r_res <= {r_res[LW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[LW+1:0];
                    r_res <= {r_res[LW-2:0], 1'b0};
                end
            end
            S_VT: begin
                r_vt <= w_vq * w_tt;
            end
            S_CHK: begin
                r_k      <= LW'(r_vt - KW'(r_res));
                r_status <= n_status;
            end
            default: ;
        endcase
    end

    assign o_start     = r_start;
    assign o_mag       = {w_mag[2], w_mag[1], w_mag[0]};
    assign o_neg       = w_neg;
    assign o_vq        = w_vq;
    assign o_t0        = r_t0;
    assign o_t1        = r_t1;
    assign o_tt        = w_tt;
    assign o_lq        = r_res;
    assign o_k         = r_k;
    assign o_st.ok     = r_ok;
    assign o_st.status = r_status;
endmodule

// ===== sv/lspb_front.sv =====
// ----------------------------------------------------------------------------
// lspb_front
// Accepts sample ticks, clamps them to the move, forms the time products
// and classifies the segment before queueing the sample.
// ----------------------------------------------------------------------------
module lspb_front #(
    parameter int COORD_BITS = 20,
    parameter int TIME_BITS  = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    lspb_in_if.sink                                 i_in,
    input  lspb_pkg::t_cfg_st                       i_st,
    input  logic [COORD_BITS+7:0]                   i_vq,
    input  logic [TIME_BITS-1:0]                    i_t0,
    input  logic [TIME_BITS-1:0]                    i_t1,
    input  logic [TIME_BITS-1:0]                    i_tt,
    input  logic [COORD_BITS+8:0]                   i_k,
    output logic                                    o_push_valid,
    output logic [lspb_pkg::CL_BITS+COORD_BITS+9:0] o_push_data,
    input  logic                                    i_push_ready
);
    localparam int LW = COORD_BITS + 9;
    localparam int OW = LW + 1;
    localparam int VW = COORD_BITS + 8;
    localparam int KW = VW + TIME_BITS;

    logic                 r_v1, r_v2;
    logic [TIME_BITS-1:0] r_tau;
    logic [KW-1:0]        r_u, r_w;
    logic                 w_take2, w_take1;
    logic [KW:0]          w_cru;
    logic [1:0]           w_cls;
    logic [OW-1:0]        w_val;

    assign w_take2    = !r_v2 || i_push_ready;
    assign w_take1    = !r_v1 || w_take2;
    assign i_in.ready = i_st.ok && w_take1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_take1) begin
                r_v1 <= i_in.valid && i_in.ready;
            end
            if (w_take2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            priority if (i_in.sample_time <= i_t0) begin
                r_tau <= '0;
            end else if (i_in.sample_time >= i_t1) begin
                r_tau <= i_tt;
            end else begin
                r_tau <= i_in.sample_time - i_t0;
            end
        end
        if (w_take2 && r_v1) begin
            r_u <= i_vq * r_tau;
            r_w <= i_vq * (i_tt - r_tau);
        end
    end

    assign w_cru = {r_u, 1'b0} - (KW+1)'(i_k);

    always_comb begin
        priority if (i_st.status != lspb_pkg::ST_OK) begin
            w_cls = lspb_pkg::CL_HOLD;
            w_val = '0;
        end else if (r_u <= KW'(i_k)) begin
            w_cls = lspb_pkg::CL_ACC;
            w_val = r_u[OW-1:0];
        end else if (r_w <= KW'(i_k)) begin
            w_cls = lspb_pkg::CL_DEC;
            w_val = r_w[OW-1:0];
        end else begin
            w_cls = lspb_pkg::CL_CRU;
            w_val = w_cru[OW-1:0];
        end
    end

    assign o_push_valid = r_v2;
    assign o_push_data  = {w_cls, w_val};
endmodule

// ===== sv/lspb_fifo.sv =====
// ----------------------------------------------------------------------------
// lspb_fifo
// Two-entry queue between the classifier and the evaluator.
// ----------------------------------------------------------------------------
module lspb_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output logic [WIDTH-1:0] o_pop_data,
    input  logic             i_pop_ready
);
    localparam int DEPTH = 2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end
endmodule

// ===== sv/lspb_back.sv =====
// ----------------------------------------------------------------------------
// lspb_back
// Evaluator: a sequencer over one shared multiplier and one bit-serial
// divider produces path distance, path speed and the per-axis shares.
// ----------------------------------------------------------------------------
module lspb_back #(
    parameter int COORD_BITS = 20
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_pop_valid,
    input  logic [lspb_pkg::CL_BITS+COORD_BITS+9:0] i_pop_data,
    output logic                                    o_pop_ready,
    input  lspb_pkg::t_cfg_st                       i_st,
    input  logic [3*COORD_BITS-1:0]                 i_start,
    input  logic [3*COORD_BITS-1:0]                 i_mag,
    input  logic [2:0]                              i_neg,
    input  logic [COORD_BITS+7:0]                   i_vq,
    input  logic [COORD_BITS+8:0]                   i_lq,
    input  logic [COORD_BITS+8:0]                   i_k,
    lspb_out_if.source                              o_out
);
    localparam int CB  = COORD_BITS;
    localparam int LW  = CB + 9;
    localparam int VW  = CB + 8;
    localparam int OW  = LW + 1;
    localparam int PW  = 2 * OW;
    localparam int NW  = PW + 1;
    localparam int DVW = LW + 2;
    localparam int QL  = LW;
    localparam int QS  = CB + 3;
    localparam int CW  = $clog2(QL + 1);
    localparam int SW  = CB + 5;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_LD   = 3'd2;
    localparam logic [2:0] B_DIV  = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    // step order: distance square, speed, three positions, three velocities
    localparam logic [2:0] PH_SQ   = 3'd0;
    localparam logic [2:0] PH_SP   = 3'd1;
    localparam logic [2:0] PH_POS  = 3'd2;
    localparam logic [2:0] PH_VEL  = 3'd5;
    localparam logic [2:0] PH_LAST = 3'd7;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-CB+1){1'b1}}, {(CB-1){1'b0}}};

    logic [2:0]      r_st, r_ph;
    logic [1:0]      r_cls;
    logic [OW-1:0]   r_x, r_pd;
    logic [VW-1:0]   r_sp;
    logic [QS-1:0]   r_q [6];
    logic [PW-1:0]   r_prod;
    logic [DVW-1:0]  r_rem;
    logic [QL-1:0]   r_dq;
    logic [CW-1:0]   r_cnt;
    logic            r_ov;
    logic [CB-1:0]   r_pos [3];
    logic [CB-1:0]   r_vel [3];
    logic [1:0]      r_ostat;

    logic [1:0]      w_pcls;
    logic [OW-1:0]   w_pval;
    logic [1:0]      w_ax;
    logic [CB-1:0]   w_m;
    logic [OW-1:0]   w_a, w_b;
    logic [DVW-1:0]  w_add, w_dv;
    logic            w_long;
    logic [NW-1:0]   w_n;
    logic [DVW:0]    w_rem2;
    logic            w_ge;
    logic [QL-1:0]   n_dq;
    logic            w_last;
    logic            w_load;
    logic [2:0]      w_qi;
    logic [CB-1:0]   n_pos [3];
    logic [CB-1:0]   n_vel [3];

    function automatic logic [CB-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return c[CB-1:0];
    endfunction

    assign w_pcls = i_pop_data[OW+1:OW];
    assign w_pval = i_pop_data[OW-1:0];

    assign o_pop_ready = (r_st == B_IDLE);

    assign w_ax = (r_ph < PH_VEL) ? 2'(r_ph - PH_POS) : 2'(r_ph - PH_VEL);
    assign w_m  = i_mag[w_ax*CB +: CB];
    assign w_qi = r_ph - PH_POS;

    always_comb begin
        priority if (r_ph == PH_SQ) begin
            w_a = r_x;                w_b = r_x;
            w_add = '0;               w_dv = DVW'(i_k);
            w_long = 1'b1;
        end else if (r_ph == PH_SP) begin
            w_a = OW'(i_vq);          w_b = r_x;
            w_add = '0;               w_dv = DVW'(i_k);
            w_long = 1'b1;
        end else if (r_ph < PH_VEL) begin
            w_a = OW'({w_m, 1'b0});   w_b = r_pd;
            w_add = DVW'({i_lq, 1'b0});
            w_dv = {i_lq, 2'b00};
            w_long = 1'b0;
        end else begin
            w_a = OW'({w_m, 1'b0});   w_b = OW'(r_sp);
            w_add = DVW'(i_lq);
            w_dv = DVW'({i_lq, 1'b0});
            w_long = 1'b0;
        end
    end

    assign w_n    = NW'(r_prod) + NW'(w_add);
    assign w_rem2 = {r_rem, r_dq[QL-1]};
    assign w_ge   = (w_rem2 >= {1'b0, w_dv});
    assign n_dq   = {r_dq[QL-2:0], w_ge};
    assign w_last = (r_cnt == CW'(1));
    assign w_load = (r_st == B_OUT) && (!r_ov || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_ov <= 1'b0;
        end else begin
            unique case (r_st)
                B_IDLE: begin
                    if (i_pop_valid) begin
                        r_st <= (w_pcls == lspb_pkg::CL_HOLD) ? B_OUT : B_MUL;
                    end
                end
                B_MUL: r_st <= B_LD;
                B_LD:  r_st <= B_DIV;
                B_DIV: begin
                    if (w_last) begin
                        r_st <= (r_ph == PH_LAST) ? B_OUT : B_MUL;
                    end
                end
                B_OUT: begin
                    if (w_load) begin
                        r_st <= B_IDLE;
                    end
                end
                default: r_st <= B_IDLE;
            endcase
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            B_IDLE: begin
                r_cls <= w_pcls;
                r_x   <= w_pval;
                r_pd  <= w_pval;
                r_sp  <= i_vq;
                r_ph  <= (w_pcls == lspb_pkg::CL_CRU) ? PH_POS : PH_SQ;
            end
            B_MUL: begin
                r_prod <= w_a * w_b;
            end
            B_LD: begin
                r_cnt <= w_long ? CW'(QL) : CW'(QS);
                if (w_long) begin
                    r_rem <= DVW'(w_n >> QL);
                    r_dq  <= w_n[QL-1:0];
                end else begin
                    r_rem <= DVW'(w_n >> QS);
                    r_dq  <= {w_n[QS-1:0], {(QL-QS){1'b0}}};
                end
            end
            B_DIV: begin
                r_rem <= w_ge ? DVW'(w_rem2 - {1'b0, w_dv}) : w_rem2[DVW-1:0];
                r_dq  <= n_dq;
                r_cnt <= r_cnt - 1'b1;
                if (w_last) begin
                    r_ph <= r_ph + 1'b1;
                    priority if (r_ph == PH_SQ) begin
                        r_pd <= (r_cls == lspb_pkg::CL_ACC) ? OW'(n_dq[LW-1:0]) :
                                {i_lq, 1'b0} - OW'(n_dq[LW-1:0]);
                    end else if (r_ph == PH_SP) begin
                        r_sp <= n_dq[VW-1:0];
                    end else begin
                        r_q[w_qi] <= n_dq[QS-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // apply signs, add start point, saturate; a hold sample gives the start point and zero velocity
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [SW-1:0] s, qp, qv;
            s  = SW'(signed'(i_start[a*CB +: CB]));
            qp = signed'({2'b00, r_q[a]});
            qv = signed'({2'b00, r_q[a+3]});
            if (i_neg[a]) begin
                qp = -qp;
                qv = -qv;
            end
            if (r_cls == lspb_pkg::CL_HOLD) begin
                n_pos[a] = i_start[a*CB +: CB];
                n_vel[a] = '0;
            end else begin
                n_pos[a] = sat(s + qp);
                n_vel[a] = sat(qv);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int a = 0; a < 3; a++) begin
                r_pos[a] <= n_pos[a];
                r_vel[a] <= n_vel[a];
            end
            r_ostat <= i_st.status;
        end
    end

    assign o_out.valid  = r_ov;
    assign o_out.pos_x  = r_pos[0];
    assign o_out.pos_y  = r_pos[1];
    assign o_out.pos_z  = r_pos[2];
    assign o_out.vel_x  = r_vel[0];
    assign o_out.vel_y  = r_vel[1];
    assign o_out.vel_z  = r_vel[2];
    assign o_out.status = r_ostat;
endmodule

// ===== sv/lspb_cartesian_trajectory_unit.sv =====
// Data path: a sample passes the two front registers, the queue, then the evaluator.
// A cruise sample skips the distance and speed divisions, and a flagged move skips
// the evaluator's multiplier and divider. The bit-serial divider dominates: the evaluator
// takes no new sample until the last result has been loaded into the output register.
// Reset clears the control registers and runs setup, as after every register
// write; no sample is accepted until then.
// ----------------------------------------------------------------------------
// lspb_cartesian_trajectory_unit
// Three-axis trapezoidal-speed straight-line move evaluated at sample ticks.
// ----------------------------------------------------------------------------
module lspb_cartesian_trajectory_unit #(
    parameter int COORD_BITS = 20,
    parameter int TIME_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lspb_pkg::REG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [3*COORD_BITS-1:0]           i_cfg_wdata,
    lspb_in_if.sink                           i_in,
    lspb_out_if.source                        o_out
);
    localparam int LW = COORD_BITS + 9;
    localparam int VW = COORD_BITS + 8;
    localparam int EW = lspb_pkg::CL_BITS + LW + 1;

    lspb_pkg::t_cfg_st       w_st;
    logic [3*COORD_BITS-1:0] w_start, w_mag;
    logic [2:0]              w_neg;
    logic [VW-1:0]           w_vq;
    logic [TIME_BITS-1:0]    w_t0, w_t1, w_tt;
    logic [LW-1:0]           w_lq, w_k;
    logic                    w_push_valid, w_push_ready, w_pop_valid, w_pop_ready;
    logic [EW-1:0]           w_push_data, w_pop_data;

    lspb_cfg #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_start     (w_start),
        .o_mag       (w_mag),
        .o_neg       (w_neg),
        .o_vq        (w_vq),
        .o_t0        (w_t0),
        .o_t1        (w_t1),
        .o_tt        (w_tt),
        .o_lq        (w_lq),
        .o_k         (w_k),
        .o_st        (w_st)
    );

    lspb_front #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_st         (w_st),
        .i_vq         (w_vq),
        .i_t0         (w_t0),
        .i_t1         (w_t1),
        .i_tt         (w_tt),
        .i_k          (w_k),
        .o_push_valid (w_push_valid),
        .o_push_data  (w_push_data),
        .i_push_ready (w_push_ready)
    );

    lspb_fifo #(
        .WIDTH (EW)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_data  (w_push_data),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_data   (w_pop_data),
        .i_pop_ready  (w_pop_ready)
    );

    lspb_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_data  (w_pop_data),
        .o_pop_ready (w_pop_ready),
        .i_st        (w_st),
        .i_start     (w_start),
        .i_mag       (w_mag),
        .i_neg       (w_neg),
        .i_vq        (w_vq),
        .i_lq        (w_lq),
        .i_k         (w_k),
        .o_out       (o_out)
    );
endmodule

// ===== dv/tb_lspb_cartesian_trajectory_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lspb_cartesian_trajectory_unit
// Self-checking bench for the LSPB trajectory unit. A directed table covers
// the flagged moves, the clamps outside the move, the segment boundaries and
// velocity saturation. Random move settings follow, each with a burst of
// sample ticks. Every result is compared against its table entry or an in-bench
// model of the move.
// ----------------------------------------------------------------------------
module tb_lspb_cartesian_trajectory_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB         = 20;
    localparam int TB         = 32;
    localparam int SETTLE     = 250;
    localparam int HOLD_LEN   = 3000;
    localparam int WDOG_LIMIT = 12000;
    localparam int N_PHASES   = 30;
    localparam int PHASE_LEN  = 61;

    typedef logic signed [CB-1:0] t_coord;

    typedef struct {
        t_coord     px, py, pz;
        t_coord     vx, vy, vz;
        logic [1:0] status;
    } t_sample_res;

    typedef struct packed {
        logic [3*CB-1:0] start_pt;
        logic [3*CB-1:0] end_pt;
        logic [CB-1:0]   speed;
        logic [TB-1:0]   t0;
        logic [TB-1:0]   t1;
    } t_move_cfg;

    typedef struct {
        t_move_cfg     cfg;
        logic [TB-1:0] t;
        bit            known;
        t_sample_res   res;
    } t_dir_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [lspb_pkg::REG_IDX_BITS-1:0] i_cfg_idx;
    logic [3*CB-1:0]                   i_cfg_wdata;

    lspb_in_if  #(.TIME_BITS(TB))  in_ch ();
    lspb_out_if #(.COORD_BITS(CB)) out_ch ();

    lspb_cartesian_trajectory_unit #(
        .COORD_BITS(CB),
        .TIME_BITS (TB)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_move_cfg   move_now;
    t_sample_res pending_samples[$];
    int          errors      = 0;
    int          idle_cycles = 0;
    bit          quiet       = 1'b0;
    bit          hold_req    = 1'b0;

    // ------------------------------------------------------------------
    // move model
    // ------------------------------------------------------------------
    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p / {64'd0, c};
        return p[63:0];
    endfunction

    function automatic longint share_round(longint d, logic [63:0] num, logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        q   = (64'd2 * mag * num + den) / (64'd2 * den);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (CB - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic logic [63:0] path_len(t_move_cfg c);
        longint      d;
        logic [63:0] sq;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            d  = longint'($signed(c.end_pt[i*CB +: CB])) -
                 longint'($signed(c.start_pt[i*CB +: CB]));
            sq += 64'(d * d);
        end
        return (sq == 0) ? 64'd0 : int_sqrt(sq << 16);
    endfunction

    function automatic t_sample_res predict_sample(t_move_cfg c, logic [TB-1:0] t);
        longint      s[3];
        longint      d[3];
        longint      pos[3];
        longint      vel[3];
        logic [63:0] sumsq, lq, vq, tt, vt, k, tau, u, w, pd, sp;
        t_sample_res r;
        sumsq    = 0;
        r.status = lspb_pkg::ST_OK;
        for (int i = 0; i < 3; i++) begin
            s[i]   = longint'($signed(c.start_pt[i*CB +: CB]));
            d[i]   = longint'($signed(c.end_pt[i*CB +: CB])) - s[i];
            sumsq += 64'(d[i] * d[i]);
            pos[i] = s[i];
            vel[i] = 0;
        end
        if (sumsq == 0) begin
            r.status = lspb_pkg::ST_ZERO;
        end else if (c.t1 <= c.t0) begin
            r.status = lspb_pkg::ST_INFEAS;
        end else begin
            lq = int_sqrt(sumsq << 16);
            vq = 64'(c.speed) << 8;
            tt = 64'(c.t1 - c.t0);
            vt = vq * tt;
            if (!(vt > lq && vt <= 64'd2 * lq)) begin
                r.status = lspb_pkg::ST_INFEAS;
            end else begin
                k   = vt - lq;
                tau = (t <= c.t0) ? 64'd0 : ((t >= c.t1) ? tt : 64'(t - c.t0));
                u   = vq * tau;
                w   = vq * (tt - tau);
                if (u <= k) begin
                    pd = mul_div(u, u, k);
                    sp = mul_div(vq, u, k);
                end else if (w <= k) begin
                    pd = 64'd2 * lq - mul_div(w, w, k);
                    sp = mul_div(vq, w, k);
                end else begin
                    pd = 64'd2 * u - k;
                    sp = vq;
                end
                for (int i = 0; i < 3; i++) begin
                    pos[i] = clamp_coord(s[i] + share_round(d[i], pd, 64'd2 * lq));
                    vel[i] = clamp_coord(share_round(d[i], sp, lq));
                end
            end
        end
        r.px = pos[0][CB-1:0]; r.py = pos[1][CB-1:0]; r.pz = pos[2][CB-1:0];
        r.vx = vel[0][CB-1:0]; r.vy = vel[1][CB-1:0]; r.vz = vel[2][CB-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 60);
    endfunction

    task automatic wait_drained();
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_move(t_move_cfg c);
        wait_drained();
        for (int r = lspb_pkg::REG_START; r <= lspb_pkg::REG_T1; r++) begin
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= r[lspb_pkg::REG_IDX_BITS-1:0];
            case (r[lspb_pkg::REG_IDX_BITS-1:0])
                lspb_pkg::REG_START: i_cfg_wdata <= c.start_pt;
                lspb_pkg::REG_END:   i_cfg_wdata <= c.end_pt;
                lspb_pkg::REG_SPEED: i_cfg_wdata <= 60'(c.speed);
                lspb_pkg::REG_T0:    i_cfg_wdata <= 60'(c.t0);
                default:             i_cfg_wdata <= 60'(c.t1);
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        move_now = c;
    endtask

    task automatic send_sample(logic [TB-1:0] t, bit known, t_sample_res res);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.sample_time <= t;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_samples.push_back(known ? res : predict_sample(move_now, t));
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [3*CB-1:0] pt(int x, int y, int z);
        return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
    endfunction

    function automatic logic [CB-1:0] rand_coord();
        int sh;
        sh = $urandom_range(0, CB - 1);
        return CB'($urandom() >> (32 - CB + sh));
    endfunction

    function automatic logic [3*CB-1:0] rand_point();
        logic [3*CB-1:0] p;
        for (int i = 0; i < 3; i++) begin
            p[i*CB +: CB] = ($urandom_range(0, 3) == 0) ? CB'($urandom()) : rand_coord();
            if ($urandom_range(0, 1)) p[i*CB +: CB] = -p[i*CB +: CB];
        end
        return p;
    endfunction

    // feasible move: pick speed, then a duration inside (lq, 2*lq]/vq
    function automatic t_move_cfg rand_feasible();
        t_move_cfg   c;
        logic [63:0] lq, vq, lo, hi, span;
        c.start_pt = rand_point();
        do c.end_pt = ($urandom_range(0, 3) == 0) ?
                      (c.start_pt ^ pt($urandom_range(0, 255), 0, 0)) : rand_point();
        while (path_len(c) == 0);
        lq = path_len(c);
        for (int a = 0; a < 60; a++) begin
            c.speed = CB'($urandom() & ((32'd1 << $urandom_range(1, CB)) - 1));
            if (c.speed == 0 || a == 59) c.speed = CB'(1);
            vq = 64'(c.speed) << 8;
            lo = lq / vq + 1;
            hi = (64'd2 * lq) / vq;
            if (lo <= hi && hi < 64'h8000_0000) break;
        end
        span = lo + (($urandom() | (64'($urandom()) << 32)) % (hi - lo + 1));
        c.t0 = $urandom_range(0, 32'hFFFF_FFFF - 32'(span));
        c.t1 = c.t0 + 32'(span);
        return c;
    endfunction

    function automatic logic [TB-1:0] rand_tick(t_move_cfg c);
        logic [TB-1:0] tt, tb_ticks;
        logic [63:0]   vq;
        int            r;
        tt = c.t1 - c.t0;
        vq = 64'(c.speed) << 8;
        tb_ticks = (vq == 0) ? '0 : 32'(((vq * 64'(tt)) - path_len(c)) / vq);
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom();
        if (r < 24) begin
            case ($urandom_range(0, 7))
                0: return c.t0;
                1: return c.t1;
                2: return c.t0 - 1;
                3: return c.t1 + 1;
                4: return c.t0 + tb_ticks;
                5: return c.t0 + tb_ticks + 1;
                6: return c.t1 - tb_ticks;
                default: return c.t1 - tb_ticks - 1;
            endcase
        end
        if (r < 30) return c.t0 - $urandom_range(0, 50);
        if (r < 36) return c.t1 + $urandom_range(0, 50);
        return c.t0 + $urandom_range(0, tt);
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            begin
                int gap;
                gap = pick_gap();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    function automatic void check_field(string nm, logic [CB-1:0] e, logic [CB-1:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch expected %0d actual %0d",
                     $time, nm, $signed(e), $signed(a));
        end
    endfunction

    always @(posedge i_clk) begin
        t_sample_res e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_samples.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, status %0d",
                         $time, out_ch.status);
            end else begin
                e = pending_samples.pop_front();
                check_field("pos_x", e.px, out_ch.pos_x);
                check_field("pos_y", e.py, out_ch.pos_y);
                check_field("pos_z", e.pz, out_ch.pos_z);
                check_field("vel_x", e.vx, out_ch.vel_x);
                check_field("vel_y", e.vy, out_ch.vel_y);
                check_field("vel_z", e.vz, out_ch.vel_z);
                check_field("status", CB'(e.status), CB'(out_ch.status));
            end
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    t_dir_row dir_rows[$];

    function automatic t_sample_res at_point(logic [3*CB-1:0] p, logic [1:0] st);
        t_sample_res r;
        r.px = p[0 +: CB]; r.py = p[CB +: CB]; r.pz = p[2*CB +: CB];
        r.vx = '0; r.vy = '0; r.vz = '0;
        r.status = st;
        return r;
    endfunction

    function automatic void add_row(t_move_cfg c, logic [TB-1:0] t, bit known,
                                    logic [3*CB-1:0] p, logic [1:0] st);
        t_dir_row row;
        row.cfg   = c;
        row.t     = t;
        row.known = known;
        row.res   = at_point(p, st);
        dir_rows.push_back(row);
    endfunction

    initial begin
        t_move_cfg c;
        t_move_cfg zc;
        int        kind;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= lspb_pkg::REG_START;
        i_cfg_wdata       <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.sample_time <= '0;
        zc       = '{default: '0};
        move_now = zc;

        // after reset: zero-length move
        add_row(zc, 0, 1, pt(0, 0, 0), lspb_pkg::ST_ZERO);
        c = '{pt(100, -200, 300), pt(100, -200, 300), 10, 0, 100};
        add_row(c, 50, 1, pt(100, -200, 300), lspb_pkg::ST_ZERO);
        // 2560-unit move along x, feasible speeds are 129..256
        c = '{pt(0, 0, 0), pt(2560, 0, 0), 192, 1000, 1000};
        add_row(c, 1000, 1, pt(0, 0, 0), lspb_pkg::ST_INFEAS);
        c.t0 = 2000;
        add_row(c, 1500, 1, pt(0, 0, 0), lspb_pkg::ST_INFEAS);
        c.t0 = 1000; c.t1 = 1020; c.speed = 0;
        add_row(c, 1010, 1, pt(0, 0, 0), lspb_pkg::ST_INFEAS);
        c.speed = 128;
        add_row(c, 1010, 1, pt(0, 0, 0), lspb_pkg::ST_INFEAS);
        c.speed = 257;
        add_row(c, 1010, 1, pt(0, 0, 0), lspb_pkg::ST_INFEAS);
        c.speed = 256;
        add_row(c, 999, 1, pt(0, 0, 0), lspb_pkg::ST_OK);
        add_row(c, 1000, 1, pt(0, 0, 0), lspb_pkg::ST_OK);
        add_row(c, 1020, 1, pt(2560, 0, 0), lspb_pkg::ST_OK);
        add_row(c, 32'hFFFF_FFFF, 1, pt(2560, 0, 0), lspb_pkg::ST_OK);
        add_row(c, 1010, 0, 0, lspb_pkg::ST_OK);
        c.speed = 192;
        add_row(c, 1006, 0, 0, lspb_pkg::ST_OK);
        add_row(c, 1007, 0, 0, lspb_pkg::ST_OK);
        add_row(c, 1010, 0, 0, lspb_pkg::ST_OK);
        add_row(c, 1013, 0, 0, lspb_pkg::ST_OK);
        add_row(c, 1014, 0, 0, lspb_pkg::ST_OK);
        // corner to corner, full coordinate range
        c = '{pt(-524288, -524288, -524288), pt(524287, 524287, 524287), 1, 0, 3000000};
        add_row(c, 0, 1, pt(-524288, -524288, -524288), lspb_pkg::ST_OK);
        add_row(c, 1500000, 0, 0, lspb_pkg::ST_OK);
        add_row(c, 3000000, 1, pt(524287, 524287, 524287), lspb_pkg::ST_OK);
        // cruise speed above the velocity range
        c = '{pt(-300000, 5, -7), pt(300000, 5, -7), 550000, 10, 12};
        add_row(c, 11, 0, 0, lspb_pkg::ST_OK);
        add_row(c, 12, 1, pt(300000, 5, -7), lspb_pkg::ST_OK);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg != move_now) begin
                in_ch.valid <= 1'b0;
                load_move(dir_rows[i].cfg);
            end
            send_sample(dir_rows[i].t, dir_rows[i].known, dir_rows[i].res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            kind = $urandom_range(0, 99);
            if (kind < 72) begin
                c = rand_feasible();
            end else if (kind < 88) begin
                c = '{rand_point(), rand_point(), CB'($urandom()), $urandom(), $urandom()};
            end else begin
                c.start_pt = rand_point();
                c.end_pt   = c.start_pt;
                c.speed    = CB'($urandom());
                c.t0       = $urandom();
                c.t1       = $urandom();
            end
            in_ch.valid <= 1'b0;
            load_move(c);
            quiet = (ph % 5 == 2);
            if (ph == 7) hold_req = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++) send_sample(rand_tick(c), 0, at_point(0, 0));
        end
        in_ch.valid <= 1'b0;

        wait_drained();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
